// ----- rtl/aes_pkg.sv -----
// ----------------------------------------------------------------------------
// aes_pkg: shared definitions for the adaptive EMA smoother
// Widths, weight register map, class codes and reset values.
// ----------------------------------------------------------------------------
package aes_pkg;

    localparam int SAMPLE_W    = 24;
    localparam int WEIGHT_W    = 17;
    localparam int CLASS_W     = 3;
    localparam int CFG_INDEX_W = 3;
    localparam int NUM_WEIGHTS = 7;
    localparam int FRAC_W      = 16;

    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(65536);

    // register indexes on the configuration channel
    localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_ZERO   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_TINY   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_SMALL  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_MEDIUM = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_LARGE  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_HUGE   = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_JUMP   = 3'd6;

    // step classes; each selects the weight register of the same index
    localparam logic [CLASS_W-1:0] CLASS_ZERO   = 3'd0;
    localparam logic [CLASS_W-1:0] CLASS_TINY   = 3'd1;
    localparam logic [CLASS_W-1:0] CLASS_SMALL  = 3'd2;
    localparam logic [CLASS_W-1:0] CLASS_MEDIUM = 3'd3;
    localparam logic [CLASS_W-1:0] CLASS_LARGE  = 3'd4;
    localparam logic [CLASS_W-1:0] CLASS_HUGE   = 3'd5;
    localparam logic [CLASS_W-1:0] CLASS_JUMP   = 3'd6;

    typedef logic [NUM_WEIGHTS-1:0][WEIGHT_W-1:0] weight_array_t;

    localparam weight_array_t WEIGHT_RESET = {
        WEIGHT_W'(65536),
        WEIGHT_W'(52429),
        WEIGHT_W'(49152),
        WEIGHT_W'(45875),
        WEIGHT_W'(6554),
        WEIGHT_W'(13107),
        WEIGHT_W'(9830)
    };

endpackage

// ----- rtl/aes_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// aes_cfg_regs: weight register bank
// Seven Q1.16 weights written over the configuration channel.
// ----------------------------------------------------------------------------
module aes_cfg_regs
    import aes_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [WEIGHT_W-1:0]    cfg_data,
    output weight_array_t          weights
);

    weight_array_t weights_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weights_reg <= WEIGHT_RESET;
        end
        else if (cfg_valid && (cfg_index <= REG_WEIGHT_JUMP))
        begin
            // indexes past the last register are dropped
            weights_reg[cfg_index] <= cfg_data;
        end
    end

    assign weights = weights_reg;

endmodule

// ----- rtl/adaptive_ema_smoother_top.sv -----
// ----------------------------------------------------------------------------
// adaptive_ema_smoother_top: adaptive exponential moving average
// Step-dependent weight selection and rounded EMA update per sample.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one unsigned Q16.8 sample per transaction in tdata.
//   m_axis returns one result per sample: smoothed average in tdata and the
//   weight class (0..6) in tuser. The first sample after reset passes
//   straight through with class 6.
//   cfg writes weight register cfg_index (0..6) with cfg_data; other
//   indexes are ignored. cfg_ready is always high; write only when idle.
// Timing:
//   Two registers deep: the input register and the result register. One
//   sample per cycle sustained while m_axis_tready is high; the step
//   classification sits in front of the input register and the single 18x25
//   multiply plus rounding add sits between input and result register.
// Reset and stalls:
//   rst_n clears the pipeline, the average, previous sample and the primed
//   flag, and loads the default weights. When m_axis_tready is low the
//   result holds, one more sample is taken into the input register, then
//   s_axis_tready drops until the result is taken.
// ----------------------------------------------------------------------------
module adaptive_ema_smoother_top
    import aes_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [SAMPLE_W-1:0]    s_axis_tdata,   // [23:0] sample
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [SAMPLE_W-1:0]    m_axis_tdata,   // [23:0] smoothed
    output logic [CLASS_W-1:0]     m_axis_tuser,   // [2:0] weight_class
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [WEIGHT_W-1:0]    cfg_data
);

    localparam int PROD_W = WEIGHT_W + SAMPLE_W + 2;

    localparam logic [SAMPLE_W-1:0] STEP_LIMIT_TINY   = SAMPLE_W'(168);
    localparam logic [SAMPLE_W-1:0] STEP_LIMIT_SMALL  = SAMPLE_W'(767);
    localparam logic [SAMPLE_W-1:0] STEP_LIMIT_MEDIUM = SAMPLE_W'(1365);
    localparam logic [SAMPLE_W-1:0] STEP_LIMIT_LARGE  = SAMPLE_W'(1791);
    localparam logic [SAMPLE_W-1:0] STEP_LIMIT_HUGE   = SAMPLE_W'(2559);

    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(32768);

    weight_array_t weights;

    logic                 in_accept;
    logic                 s1_advance;
    logic                 primed_reg;
    logic [SAMPLE_W-1:0]  prev_sample_reg;
    logic [SAMPLE_W-1:0]  step;
    logic [CLASS_W-1:0]   step_class;

    logic                 s1_valid_reg;
    logic                 s1_first_reg;
    logic [SAMPLE_W-1:0]  s1_sample_reg;
    logic [CLASS_W-1:0]   s1_class_reg;

    logic [SAMPLE_W-1:0]  avg_reg;
    logic [SAMPLE_W-1:0]  avg_next;

    logic [WEIGHT_W-1:0]        w_raw;
    logic [WEIGHT_W-1:0]        w_sat;
    logic signed [SAMPLE_W:0]   diff;
    logic signed [PROD_W-1:0]   prod;
    logic signed [PROD_W-1:0]   num;

    logic                 out_valid_reg;
    logic [SAMPLE_W-1:0]  out_smoothed_reg;
    logic [CLASS_W-1:0]   out_class_reg;

    aes_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .weights   (weights)
    );

    assign cfg_ready = 1'b1;

    assign s1_advance    = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || s1_advance;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // front end: step against the last accepted sample
    always_comb
    begin
        step = (s_axis_tdata > prev_sample_reg) ? (s_axis_tdata - prev_sample_reg)
                                                 : (prev_sample_reg - s_axis_tdata);
        if (step == '0)
            step_class = CLASS_ZERO;
        else if (step <= STEP_LIMIT_TINY)
            step_class = CLASS_TINY;
        else if (step <= STEP_LIMIT_SMALL)
            step_class = CLASS_SMALL;
        else if (step <= STEP_LIMIT_MEDIUM)
            step_class = CLASS_MEDIUM;
        else if (step <= STEP_LIMIT_LARGE)
            step_class = CLASS_LARGE;
        else if (step <= STEP_LIMIT_HUGE)
            step_class = CLASS_HUGE;
        else
            step_class = CLASS_JUMP;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primed_reg      <= 1'b0;
            prev_sample_reg <= '0;
            s1_valid_reg    <= 1'b0;
            s1_first_reg    <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                primed_reg      <= 1'b1;
                prev_sample_reg <= s_axis_tdata;
                s1_first_reg    <= !primed_reg;
            end
            if (in_accept)
                s1_valid_reg <= 1'b1;
            else if (s1_advance)
                s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_sample_reg <= s_axis_tdata;
            s1_class_reg  <= primed_reg ? step_class : CLASS_JUMP;
        end
    end

    // update: avg + w*(x - avg), rounded half up and clamped; the first sample loads directly
    always_comb
    begin
        case (s1_class_reg)
            CLASS_ZERO:   w_raw = weights[REG_WEIGHT_ZERO];
            CLASS_TINY:   w_raw = weights[REG_WEIGHT_TINY];
            CLASS_SMALL:  w_raw = weights[REG_WEIGHT_SMALL];
            CLASS_MEDIUM: w_raw = weights[REG_WEIGHT_MEDIUM];
            CLASS_LARGE:  w_raw = weights[REG_WEIGHT_LARGE];
            CLASS_HUGE:   w_raw = weights[REG_WEIGHT_HUGE];
            default:      w_raw = weights[REG_WEIGHT_JUMP];
        endcase
        w_sat = (w_raw > WEIGHT_ONE) ? WEIGHT_ONE : w_raw;
        diff  = $signed({1'b0, s1_sample_reg}) - $signed({1'b0, avg_reg});
        prod  = $signed({1'b0, w_sat}) * diff;
        num   = $signed({3'b000, avg_reg, {FRAC_W{1'b0}}}) + prod + ROUND_HALF;
        if (s1_first_reg)
            avg_next = s1_sample_reg;
        else if (num[PROD_W-1])
            avg_next = '0;
        else if (|num[PROD_W-2:SAMPLE_W+FRAC_W])
            avg_next = '1;
        else
            avg_next = num[SAMPLE_W+FRAC_W-1:FRAC_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avg_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_advance)
            begin
                avg_reg       <= avg_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            out_smoothed_reg <= avg_next;
            out_class_reg    <= s1_class_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_smoothed_reg;
    assign m_axis_tuser  = out_class_reg;

    // once primed, stays primed until reset
    assert property (@(posedge clk) disable iff (!rst_n)
        primed_reg |=> primed_reg)
        else $error("primed flag cleared without reset");

    // first sample passes through with the jump class
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance && s1_first_reg |=>
            (m_axis_tuser == CLASS_JUMP) && (m_axis_tdata == $past(s1_sample_reg)))
        else $error("first sample not passed through");

    // an unchanged sample after priming is classed as zero step
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && primed_reg && (s_axis_tdata == prev_sample_reg) |=>
            (s1_class_reg == CLASS_ZERO))
        else $error("zero step misclassified");

    // the result register only loads from a valid input register
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg && !s1_valid_reg |=> !out_valid_reg)
        else $error("result appeared without a pending sample");

endmodule
